/* rtl/lds_pkg.sv */
// Shared constants, status codes and control types of the LOOK disk request scheduler.
// Every other file of the block but lds_ram uses this package; it depends on nothing.
`default_nettype none

package lds_pkg;

   localparam int QUEUE_DEPTH  = 16;
   localparam int TRACK_WIDTH  = 12;
   localparam int ID_WIDTH     = 8;
   localparam int ADDR_WIDTH   = $clog2(QUEUE_DEPTH);
   localparam int COUNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);
   localparam int ENTRY_WIDTH  = ID_WIDTH + TRACK_WIDTH;
   localparam int STATUS_WIDTH = 2;

   typedef logic [STATUS_WIDTH-1:0] status_type;

   localparam status_type ST_ADDED  = 2'd0;
   localparam status_type ST_FULL   = 2'd1;
   localparam status_type ST_SERVED = 2'd2;
   localparam status_type ST_EMPTY  = 2'd3;

   typedef enum logic [2:0] {
      CS_IDLE,
      CS_SCAN,
      CS_DECIDE,
      CS_MOVE,
      CS_RESP
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic decide;
      logic move;
      logic out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic need_scan;
      logic scan_done;
      logic move_done;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

/* rtl/lds_if.sv */
// Valid/ready channel interfaces for the request and response sides of the scheduler.
// Depends on lds_pkg for field widths and the status type.
`default_nettype none

interface lds_req_if;
   logic                           valid;
   logic                           ready;
   logic                           mode;
   logic [lds_pkg::ID_WIDTH-1:0]    request_id;
   logic [lds_pkg::TRACK_WIDTH-1:0] request_track;
   logic [lds_pkg::TRACK_WIDTH-1:0] head_track;

   modport source (output valid, mode, request_id, request_track, head_track, input ready);
   modport sink (input valid, mode, request_id, request_track, head_track, output ready);
   modport monitor (input valid, ready, mode, request_id, request_track, head_track);
endinterface

interface lds_rsp_if;
   logic                            valid;
   logic                            ready;
   lds_pkg::status_type             status;
   logic [lds_pkg::ID_WIDTH-1:0]     served_id;
   logic [lds_pkg::TRACK_WIDTH-1:0]  served_track;
   logic                            sweep_up;
   logic [lds_pkg::COUNT_WIDTH-1:0]  pending_count;

   modport source (output valid, status, served_id, served_track, sweep_up, pending_count,
                   input ready);
   modport sink (input valid, status, served_id, served_track, sweep_up, pending_count,
                 output ready);
   modport monitor (input valid, ready, status, served_id, served_track, sweep_up,
                    pending_count);
endinterface

`default_nettype wire

/* rtl/lds_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Standalone; holds the request table of the scheduler.
`default_nettype none

module lds_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/lds_ctrl.sv */
// Control state machine of the scheduler: sequences accept, scan, decide, compaction and
// response. Depends on lds_pkg for the state, command and status types.
`default_nettype none

module lds_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  lds_pkg::dp_status_type dp_status,
   output lds_pkg::dp_cmd_type    dp_cmd
);
   import lds_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CS_IDLE: begin
            if (req_valid) begin
               state_in = dp_status.need_scan ? CS_SCAN : CS_RESP;
            end
         end
         CS_SCAN: begin
            if (dp_status.scan_done) begin
               state_in = CS_DECIDE;
            end
         end
         CS_DECIDE: begin
            state_in = CS_MOVE;
         end
         CS_MOVE: begin
            if (dp_status.move_done) begin
               state_in = CS_RESP;
            end
         end
         CS_RESP: begin
            if (dp_status.out_free) begin
               state_in = CS_IDLE;
            end
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready       = 1'b0;
      dp_cmd          = '0;
      case (state_ff)
         CS_IDLE: begin
            req_ready   = 1'b1;
            dp_cmd.load = req_valid;
         end
         CS_SCAN: begin
            dp_cmd.scan = 1'b1;
         end
         CS_DECIDE: begin
            dp_cmd.decide = 1'b1;
         end
         CS_MOVE: begin
            dp_cmd.move = 1'b1;
         end
         CS_RESP: begin
            dp_cmd.out_load = dp_status.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

/* rtl/lds_dp.sv */
// Datapath of the scheduler: entry count, sweep direction, scan comparators, compaction
// and the response register. Depends on lds_pkg; drives the ports of the table RAM.
`default_nettype none

module lds_dp (
   input  logic                             clock,
   input  logic                             reset,
   input  lds_pkg::dp_cmd_type              dp_cmd,
   output lds_pkg::dp_status_type           dp_status,
   input  logic                             req_mode,
   input  logic [lds_pkg::ID_WIDTH-1:0]     req_id,
   input  logic [lds_pkg::TRACK_WIDTH-1:0]  req_track,
   input  logic [lds_pkg::TRACK_WIDTH-1:0]  req_head,
   output logic                             ram_wr_en,
   output logic [lds_pkg::ADDR_WIDTH-1:0]   ram_wr_addr,
   output logic [lds_pkg::ENTRY_WIDTH-1:0]  ram_wr_data,
   output logic [lds_pkg::ADDR_WIDTH-1:0]   ram_rd_addr,
   input  logic [lds_pkg::ENTRY_WIDTH-1:0]  ram_rd_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output lds_pkg::status_type              rsp_status,
   output logic [lds_pkg::ID_WIDTH-1:0]     rsp_id,
   output logic [lds_pkg::TRACK_WIDTH-1:0]  rsp_track,
   output logic                             rsp_sweep,
   output logic [lds_pkg::COUNT_WIDTH-1:0]  rsp_count
);
   import lds_pkg::*;

   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   dir_ff, dir_in;
   logic [TRACK_WIDTH-1:0] head_ff, head_in;
   status_type             status_ff, status_in;

   logic [COUNT_WIDTH-1:0] scan_idx_ff, scan_idx_in;
   logic                   pend_ff, pend_in;
   logic [ADDR_WIDTH-1:0]  pend_idx_ff, pend_idx_in;

   logic                   ex_found_ff, ex_found_in;
   logic [ADDR_WIDTH-1:0]  ex_idx_ff, ex_idx_in;
   logic [ID_WIDTH-1:0]    ex_id_ff, ex_id_in;

   logic                   up_found_ff, up_found_in;
   logic [TRACK_WIDTH-1:0] up_dist_ff, up_dist_in;
   logic [ADDR_WIDTH-1:0]  up_idx_ff, up_idx_in;
   logic [ENTRY_WIDTH-1:0] up_entry_ff, up_entry_in;

   logic                   dn_found_ff, dn_found_in;
   logic [TRACK_WIDTH-1:0] dn_dist_ff, dn_dist_in;
   logic [ADDR_WIDTH-1:0]  dn_idx_ff, dn_idx_in;
   logic [ENTRY_WIDTH-1:0] dn_entry_ff, dn_entry_in;

   logic [ID_WIDTH-1:0]    sid_ff, sid_in;
   logic [TRACK_WIDTH-1:0] strk_ff, strk_in;

   logic [COUNT_WIDTH-1:0] src_ff, src_in;
   logic                   mv_pend_ff, mv_pend_in;
   logic [ADDR_WIDTH-1:0]  mv_idx_ff, mv_idx_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic [ID_WIDTH-1:0]    rsp_id_ff, rsp_id_in;
   logic [TRACK_WIDTH-1:0] rsp_track_ff, rsp_track_in;
   logic                   rsp_sweep_ff, rsp_sweep_in;
   logic [COUNT_WIDTH-1:0] rsp_count_ff, rsp_count_in;

   logic [TRACK_WIDTH-1:0] rd_track;
   logic [ID_WIDTH-1:0]    rd_id;
   logic [TRACK_WIDTH-1:0] up_dist;
   logic [TRACK_WIDTH-1:0] dn_dist;
   logic                   use_up;
   logic [ADDR_WIDTH-1:0]  pick_idx;

   assign rd_track = ram_rd_data[TRACK_WIDTH-1:0];
   assign rd_id    = ram_rd_data[ENTRY_WIDTH-1:TRACK_WIDTH];
   assign up_dist  = rd_track - head_ff;
   assign dn_dist  = head_ff - rd_track;
   assign use_up   = dir_ff ? up_found_ff : !dn_found_ff;
   assign pick_idx = ex_found_ff ? ex_idx_ff : (use_up ? up_idx_ff : dn_idx_ff);

   assign dp_status.need_scan = req_mode && (count_ff != '0);
   assign dp_status.scan_done = (scan_idx_ff >= count_ff) && !pend_ff;
   assign dp_status.move_done = (src_ff >= count_ff) && !mv_pend_ff;
   assign dp_status.out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      count_in      = count_ff;
      dir_in        = dir_ff;
      head_in       = head_ff;
      status_in     = status_ff;
      scan_idx_in   = scan_idx_ff;
      pend_in       = pend_ff;
      pend_idx_in   = pend_idx_ff;
      ex_found_in   = ex_found_ff;
      ex_idx_in     = ex_idx_ff;
      ex_id_in      = ex_id_ff;
      up_found_in   = up_found_ff;
      up_dist_in    = up_dist_ff;
      up_idx_in     = up_idx_ff;
      up_entry_in   = up_entry_ff;
      dn_found_in   = dn_found_ff;
      dn_dist_in    = dn_dist_ff;
      dn_idx_in     = dn_idx_ff;
      dn_entry_in   = dn_entry_ff;
      sid_in        = sid_ff;
      strk_in       = strk_ff;
      src_in        = src_ff;
      mv_pend_in    = mv_pend_ff;
      mv_idx_in     = mv_idx_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_track_in  = rsp_track_ff;
      rsp_sweep_in  = rsp_sweep_ff;
      rsp_count_in  = rsp_count_ff;

      ram_wr_en   = 1'b0;
      ram_wr_addr = count_ff[ADDR_WIDTH-1:0];
      ram_wr_data = {req_id, req_track};
      ram_rd_addr = scan_idx_ff[ADDR_WIDTH-1:0];

      if (dp_cmd.load) begin
         head_in     = req_head;
         scan_idx_in = '0;
         pend_in     = 1'b0;
         ex_found_in = 1'b0;
         up_found_in = 1'b0;
         dn_found_in = 1'b0;
         sid_in      = '0;
         strk_in     = '0;
         if (!req_mode) begin
            if (count_ff >= COUNT_WIDTH'(QUEUE_DEPTH)) begin
               status_in = ST_FULL;
            end else begin
               ram_wr_en = 1'b1;
               count_in  = count_ff + 1'b1;
               status_in = ST_ADDED;
            end
         end else if (count_ff == '0) begin
            status_in = ST_EMPTY;
         end else begin
            status_in = ST_SERVED;
         end
      end

      if (dp_cmd.scan) begin
         if (scan_idx_ff < count_ff) begin
            scan_idx_in = scan_idx_ff + 1'b1;
            pend_in     = 1'b1;
            pend_idx_in = scan_idx_ff[ADDR_WIDTH-1:0];
         end else begin
            pend_in = 1'b0;
         end
         if (pend_ff) begin
            if (!ex_found_ff && (rd_track == head_ff)) begin
               ex_found_in = 1'b1;
               ex_idx_in   = pend_idx_ff;
               ex_id_in    = rd_id;
            end
            if ((rd_track > head_ff) && (!up_found_ff || (up_dist < up_dist_ff))) begin
               up_found_in = 1'b1;
               up_dist_in  = up_dist;
               up_idx_in   = pend_idx_ff;
               up_entry_in = ram_rd_data;
            end
            if ((rd_track < head_ff) && (!dn_found_ff || (dn_dist < dn_dist_ff))) begin
               dn_found_in = 1'b1;
               dn_dist_in  = dn_dist;
               dn_idx_in   = pend_idx_ff;
               dn_entry_in = ram_rd_data;
            end
         end
      end

      if (dp_cmd.decide) begin
         src_in     = COUNT_WIDTH'(pick_idx) + 1'b1;
         mv_pend_in = 1'b0;
         if (ex_found_ff) begin
            sid_in  = ex_id_ff;
            strk_in = head_ff;
         end else begin
            // With nothing ahead in the current sweep, the direction reverses.
            dir_in  = use_up;
            sid_in  = use_up ? up_entry_ff[ENTRY_WIDTH-1:TRACK_WIDTH]
                             : dn_entry_ff[ENTRY_WIDTH-1:TRACK_WIDTH];
            strk_in = use_up ? up_entry_ff[TRACK_WIDTH-1:0] : dn_entry_ff[TRACK_WIDTH-1:0];
         end
      end

      if (dp_cmd.move) begin
         ram_rd_addr = src_ff[ADDR_WIDTH-1:0];
         if (src_ff < count_ff) begin
            src_in     = src_ff + 1'b1;
            mv_pend_in = 1'b1;
            mv_idx_in  = src_ff[ADDR_WIDTH-1:0];
         end else begin
            mv_pend_in = 1'b0;
         end
         if (mv_pend_ff) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = mv_idx_ff - 1'b1;
            ram_wr_data = ram_rd_data;
         end
      end

      if (dp_cmd.out_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         rsp_id_in     = sid_ff;
         rsp_track_in  = strk_ff;
         rsp_sweep_in  = dir_ff;
         rsp_count_in  = count_ff;
         if (status_ff == ST_SERVED) begin
            count_in     = count_ff - 1'b1;
            rsp_count_in = count_ff - 1'b1;
         end
      end else if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         dir_ff       <= 1'b1;
         pend_ff      <= 1'b0;
         mv_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         dir_ff       <= dir_in;
         pend_ff      <= pend_in;
         mv_pend_ff   <= mv_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff       <= head_in;
      status_ff     <= status_in;
      scan_idx_ff   <= scan_idx_in;
      pend_idx_ff   <= pend_idx_in;
      ex_found_ff   <= ex_found_in;
      ex_idx_ff     <= ex_idx_in;
      ex_id_ff      <= ex_id_in;
      up_found_ff   <= up_found_in;
      up_dist_ff    <= up_dist_in;
      up_idx_ff     <= up_idx_in;
      up_entry_ff   <= up_entry_in;
      dn_found_ff   <= dn_found_in;
      dn_dist_ff    <= dn_dist_in;
      dn_idx_ff     <= dn_idx_in;
      dn_entry_ff   <= dn_entry_in;
      sid_ff        <= sid_in;
      strk_ff       <= strk_in;
      src_ff        <= src_in;
      mv_idx_ff     <= mv_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_track_ff  <= rsp_track_in;
      rsp_sweep_ff  <= rsp_sweep_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_id     = rsp_id_ff;
   assign rsp_track  = rsp_track_ff;
   assign rsp_sweep  = rsp_sweep_ff;
   assign rsp_count  = rsp_count_ff;

endmodule

`default_nettype wire

/* rtl/look_disk_request_scheduler.sv */
// Top level of the LOOK disk request scheduler: controller, datapath and request table RAM.
// Depends on lds_pkg, lds_if, lds_ram, lds_ctrl and lds_dp.
//
//   Channel   Direction  Beat contents
//   req_bus   in         mode, request_id, request_track, head_track
//   rsp_bus   out        status, served_id, served_track, sweep_up, pending_count
//
// An add or an answer on an empty table goes from accept straight to the response step.
// A serve makes one scan of the table through the RAM read port, one decision step, then
// compaction through the same port.
// Reset empties the table and sets the sweep upward; the table RAM itself is not cleared.
// The response register holds a beat until it is taken; a new request is accepted meanwhile
// and waits in its final step until the register frees.
`default_nettype none

module look_disk_request_scheduler (
   input logic          clock,
   input logic          reset,
   lds_req_if.sink      req_bus,
   lds_rsp_if.source    rsp_bus
);
   import lds_pkg::*;

   dp_cmd_type             dp_cmd;
   dp_status_type          dp_status;
   logic                   ram_wr_en;
   logic [ADDR_WIDTH-1:0]  ram_wr_addr;
   logic [ENTRY_WIDTH-1:0] ram_wr_data;
   logic [ADDR_WIDTH-1:0]  ram_rd_addr;
   logic [ENTRY_WIDTH-1:0] ram_rd_data;

   lds_ram #(
      .WIDTH (ENTRY_WIDTH),
      .DEPTH (QUEUE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   lds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   lds_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .dp_cmd      (dp_cmd),
      .dp_status   (dp_status),
      .req_mode    (req_bus.mode),
      .req_id      (req_bus.request_id),
      .req_track   (req_bus.request_track),
      .req_head    (req_bus.head_track),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .rsp_valid   (rsp_bus.valid),
      .rsp_ready   (rsp_bus.ready),
      .rsp_status  (rsp_bus.status),
      .rsp_id      (rsp_bus.served_id),
      .rsp_track   (rsp_bus.served_track),
      .rsp_sweep   (rsp_bus.sweep_up),
      .rsp_count   (rsp_bus.pending_count)
   );

endmodule

`default_nettype wire

/* rtl/lds_checker.sv */
// Port-level assertions for the scheduler's response channel, bound to the top level.
// Depends on lds_pkg.
`default_nettype none

module lds_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input lds_pkg::status_type             rsp_status,
   input logic [lds_pkg::ID_WIDTH-1:0]    rsp_served_id,
   input logic [lds_pkg::TRACK_WIDTH-1:0] rsp_served_track,
   input logic                            rsp_sweep_up,
   input logic [lds_pkg::COUNT_WIDTH-1:0] rsp_pending_count
);
   import lds_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_served_id) && $stable(rsp_served_track)
         && $stable(rsp_sweep_up) && $stable(rsp_pending_count))
      else $error("Response beat changed while stalled.");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_FULL)
         |-> rsp_pending_count == COUNT_WIDTH'(QUEUE_DEPTH))
      else $error("Rejected add with a table that is not full.");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_EMPTY) |-> rsp_pending_count == '0)
      else $error("Nothing-pending answer with entries left.");

   a_added_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_ADDED) |-> rsp_pending_count != '0)
      else $error("Added request but the table reads empty.");

   a_unserved_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_SERVED)
         |-> (rsp_served_id == '0) && (rsp_served_track == '0))
      else $error("Served fields nonzero without a served request.");

endmodule

bind look_disk_request_scheduler lds_checker u_lds_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_status        (rsp_bus.status),
   .rsp_served_id     (rsp_bus.served_id),
   .rsp_served_track  (rsp_bus.served_track),
   .rsp_sweep_up      (rsp_bus.sweep_up),
   .rsp_pending_count (rsp_bus.pending_count)
);

`default_nettype wire

/* sim/testbench.sv */
// Self-checking testbench for the LOOK disk request scheduler: a directed table, then random
// add and serve beats checked against a behavioral model of the request table and sweep.
// Depends on lds_pkg, lds_if and the look_disk_request_scheduler RTL.
`timescale 1ns / 100ps

module testbench;
   import lds_pkg::*;

   typedef struct packed {
      logic                   mode;
      logic [ID_WIDTH-1:0]    id;
      logic [TRACK_WIDTH-1:0] track;
      logic [TRACK_WIDTH-1:0] head;
   } disk_cmd_type;

   typedef struct packed {
      status_type             status;
      logic [ID_WIDTH-1:0]    id;
      logic [TRACK_WIDTH-1:0] track;
      logic                   sweep;
      logic [COUNT_WIDTH-1:0] count;
   } disk_answer_type;

   typedef struct packed {
      disk_cmd_type    cmd;
      logic            typed;
      disk_answer_type ans;
   } plan_row_type;

   localparam logic MODE_ADD   = 1'b0;
   localparam logic MODE_SERVE = 1'b1;

   logic clock;
   logic reset = 1'b1;
   logic rsp_take = 1'b0;

   lds_req_if req_bus();
   lds_rsp_if rsp_bus();

   assign rsp_bus.ready = rsp_take;

   look_disk_request_scheduler u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   logic [ID_WIDTH-1:0]    mirror_id [QUEUE_DEPTH];
   logic [TRACK_WIDTH-1:0] mirror_track [QUEUE_DEPTH];
   int                     mirror_count = 0;
   logic                   mirror_up = 1'b1;

   disk_answer_type answers [$];
   plan_row_type    plan [$];
   int              fail_count = 0;
   int              answers_seen = 0;
   logic            quiet_link = 1'b0;
   int              stall_left = 0;
   bit              pressure_done = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

   function automatic int nearest_ahead(logic [TRACK_WIDTH-1:0] head, logic up);
      int best;
      int best_dist;
      int span;
      best = -1;
      best_dist = 0;
      for (int i = 0; i < mirror_count; i++) begin
         if (up) begin
            if (mirror_track[i] <= head) continue;
            span = int'(mirror_track[i]) - int'(head);
         end else begin
            if (mirror_track[i] >= head) continue;
            span = int'(head) - int'(mirror_track[i]);
         end
         if (best < 0 || span < best_dist) begin
            best = i;
            best_dist = span;
         end
      end
      return best;
   endfunction

   function automatic disk_answer_type look_schedule(disk_cmd_type cmd);
      disk_answer_type ans;
      int pick;
      ans = '0;
      if (cmd.mode == MODE_ADD) begin
         if (mirror_count >= QUEUE_DEPTH) begin
            ans.status = ST_FULL;
         end else begin
            mirror_id[mirror_count] = cmd.id;
            mirror_track[mirror_count] = cmd.track;
            mirror_count++;
            ans.status = ST_ADDED;
         end
      end else if (mirror_count == 0) begin
         ans.status = ST_EMPTY;
      end else begin
         pick = -1;
         for (int i = 0; i < mirror_count; i++) begin
            if (mirror_track[i] == cmd.head) begin
               pick = i;
               break;
            end
         end
         if (pick < 0) pick = nearest_ahead(cmd.head, mirror_up);
         if (pick < 0) begin
            mirror_up = ~mirror_up;
            pick = nearest_ahead(cmd.head, mirror_up);
         end
         ans.status = ST_SERVED;
         ans.id = mirror_id[pick];
         ans.track = mirror_track[pick];
         for (int i = pick; i + 1 < mirror_count; i++) begin
            mirror_id[i] = mirror_id[i + 1];
            mirror_track[i] = mirror_track[i + 1];
         end
         mirror_count--;
      end
      ans.sweep = mirror_up;
      ans.count = COUNT_WIDTH'(mirror_count);
      return ans;
   endfunction

   function automatic logic [TRACK_WIDTH-1:0] pick_track(logic [TRACK_WIDTH-1:0] cluster);
      case ($urandom_range(0, 3))
         0, 1:    return TRACK_WIDTH'($urandom);
         2:       return cluster + TRACK_WIDTH'($urandom_range(0, 7));
         default: return $urandom_range(0, 1) ? '1 : '0;
      endcase
   endfunction

   task automatic plan_row(logic mode, int id, int track, int head, logic typed,
                           status_type status, int sid, int strk, logic sweep, int count);
      plan_row_type row;
      row.cmd.mode = mode;
      row.cmd.id = ID_WIDTH'(id);
      row.cmd.track = TRACK_WIDTH'(track);
      row.cmd.head = TRACK_WIDTH'(head);
      row.typed = typed;
      row.ans.status = status;
      row.ans.id = ID_WIDTH'(sid);
      row.ans.track = TRACK_WIDTH'(strk);
      row.ans.sweep = sweep;
      row.ans.count = COUNT_WIDTH'(count);
      plan.insert(plan.size(), row);
   endtask

   task automatic send_cmd(disk_cmd_type cmd, logic typed, disk_answer_type typed_ans);
      disk_answer_type guess;
      int gap;
      int roll;
      req_bus.valid <= 1'b1;
      req_bus.mode <= cmd.mode;
      req_bus.request_id <= cmd.id;
      req_bus.request_track <= cmd.track;
      req_bus.head_track <= cmd.head;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      guess = look_schedule(cmd);
      answers.insert(answers.size(), typed ? typed_ans : guess);
      roll = $urandom_range(0, 99);
      if (quiet_link) gap = 0;
      else if (roll < 55) gap = 0;
      else if (roll < 92) gap = $urandom_range(1, 3);
      else gap = $urandom_range(10, 40);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic check_field(string name, int expected, int actual);
      if (expected != actual) begin
         $error("%s mismatch: expected %0d, got %0d", name, expected, actual);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      disk_answer_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         answers_seen <= answers_seen + 1;
         if (answers.size() == 0) begin
            $error("response beat with no request waiting");
            fail_count++;
         end else begin
            want = answers.pop_front();
            check_field("status", want.status, rsp_bus.status);
            check_field("served_id", want.id, rsp_bus.served_id);
            check_field("served_track", want.track, rsp_bus.served_track);
            check_field("sweep_up", want.sweep, rsp_bus.sweep_up);
            check_field("pending_count", want.count, rsp_bus.pending_count);
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_take <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_take <= 1'b0;
         stall_left = stall_left - 1;
      end else if (!pressure_done && answers_seen >= 300) begin
         pressure_done = 1;
         stall_left = 600;
         rsp_take <= 1'b0;
      end else if (quiet_link) begin
         rsp_take <= 1'b1;
      end else if ($urandom_range(0, 199) == 0) begin
         stall_left = $urandom_range(10, 40);
         rsp_take <= 1'b0;
      end else begin
         rsp_take <= ($urandom_range(0, 99) < 70);
      end
   end

   initial begin
      disk_cmd_type    cmd;
      disk_answer_type none;
      int              seg_left;
      int              add_bias;
      logic [TRACK_WIDTH-1:0] cluster;

      none = '0;
      seg_left = 0;
      add_bias = 50;
      cluster = '0;
      req_bus.valid <= 1'b0;
      req_bus.mode <= MODE_ADD;
      req_bus.request_id <= '0;
      req_bus.request_track <= '0;
      req_bus.head_track <= '0;
      reset <= 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      plan_row(MODE_SERVE, 0, 0, 0, 1, ST_EMPTY, 0, 0, 1, 0);
      plan_row(MODE_ADD, 255, 4095, 4095, 1, ST_ADDED, 0, 0, 1, 1);
      plan_row(MODE_ADD, 0, 0, 0, 1, ST_ADDED, 0, 0, 1, 2);
      plan_row(MODE_SERVE, 17, 33, 4095, 1, ST_SERVED, 255, 4095, 1, 1);
      plan_row(MODE_SERVE, 0, 0, 4095, 1, ST_SERVED, 0, 0, 0, 0);
      plan_row(MODE_SERVE, 0, 0, 100, 1, ST_EMPTY, 0, 0, 0, 0);
      plan_row(MODE_ADD, 1, 10, 0, 0, ST_ADDED, 0, 0, 0, 0);
      plan_row(MODE_ADD, 2, 20, 0, 0, ST_ADDED, 0, 0, 0, 0);
      plan_row(MODE_ADD, 3, 20, 0, 0, ST_ADDED, 0, 0, 0, 0);
      plan_row(MODE_ADD, 4, 30, 0, 0, ST_ADDED, 0, 0, 0, 0);
      plan_row(MODE_ADD, 5, 5, 0, 0, ST_ADDED, 0, 0, 0, 0);
      plan_row(MODE_ADD, 6, 4000, 0, 0, ST_ADDED, 0, 0, 0, 0);
      plan_row(MODE_ADD, 7, 20, 0, 0, ST_ADDED, 0, 0, 0, 0);
      plan_row(MODE_ADD, 8, 15, 0, 0, ST_ADDED, 0, 0, 0, 0);
      plan_row(MODE_ADD, 9, 35, 0, 0, ST_ADDED, 0, 0, 0, 0);
      plan_row(MODE_ADD, 10, 4095, 0, 0, ST_ADDED, 0, 0, 0, 0);
      plan_row(MODE_ADD, 11, 0, 0, 0, ST_ADDED, 0, 0, 0, 0);
      plan_row(MODE_ADD, 12, 2048, 0, 0, ST_ADDED, 0, 0, 0, 0);
      plan_row(MODE_ADD, 13, 15, 0, 0, ST_ADDED, 0, 0, 0, 0);
      plan_row(MODE_ADD, 14, 1, 0, 0, ST_ADDED, 0, 0, 0, 0);
      plan_row(MODE_ADD, 15, 4094, 0, 0, ST_ADDED, 0, 0, 0, 0);
      plan_row(MODE_ADD, 16, 25, 0, 0, ST_ADDED, 0, 0, 0, 0);
      plan_row(MODE_ADD, 200, 77, 0, 1, ST_FULL, 0, 0, 0, 16);
      plan_row(MODE_SERVE, 0, 0, 20, 0, ST_SERVED, 0, 0, 0, 0);
      plan_row(MODE_SERVE, 0, 0, 18, 0, ST_SERVED, 0, 0, 0, 0);
      plan_row(MODE_SERVE, 0, 0, 4095, 0, ST_SERVED, 0, 0, 0, 0);

      foreach (plan[i]) send_cmd(plan[i].cmd, plan[i].typed, plan[i].ans);

      for (int n = 0; n < 1200; n++) begin
         if (seg_left == 0) begin
            seg_left = $urandom_range(20, 60);
            case ($urandom_range(0, 3))
               0:       add_bias = 85;
               1:       add_bias = 15;
               default: add_bias = 50;
            endcase
            cluster = TRACK_WIDTH'($urandom);
            quiet_link <= ($urandom_range(0, 3) == 0);
         end
         seg_left--;
         cmd.mode = ($urandom_range(0, 99) >= add_bias) ? MODE_SERVE : MODE_ADD;
         cmd.id = ID_WIDTH'($urandom);
         cmd.track = pick_track(cluster);
         if (mirror_count > 0 && $urandom_range(0, 2) == 0)
            cmd.head = mirror_track[$urandom_range(0, mirror_count - 1)];
         else
            cmd.head = pick_track(cluster);
         send_cmd(cmd, 1'b0, none);
      end
      req_bus.valid <= 1'b0;

      while (answers.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
